// File: sv/spectral_tone_pair_detector_macros.svh
// ---------------------------------------------------------------------------
// Spectral tone pair detector assertion macros
// Clocked, reset-gated property shorthands used by the top level.
// ---------------------------------------------------------------------------
`ifndef SPECTRAL_TONE_PAIR_DETECTOR_MACROS_SVH
`define SPECTRAL_TONE_PAIR_DETECTOR_MACROS_SVH

// same-cycle implication
`define STPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/stpd_pkg.sv
// ---------------------------------------------------------------------------
// stpd_pkg
// Shared constants, register codes and the configuration struct.
// ---------------------------------------------------------------------------
package stpd_pkg;

  localparam int HISTORY_DEPTH_DEF = 25;
  localparam int NUM_BINS_DEF      = 512;
  localparam int QUEUE_DEPTH       = 2;

  localparam int AMP_W  = 31;
  localparam int FREQ_W = 15;
  localparam int HZ_W   = 6;
  localparam int BIN_VALUE_W = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 31;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_HZ        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIM_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIM_HIGH     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SEC_LOW       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SEC_HIGH      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LEVEL   = 3'd7;

  // register reset values
  localparam logic [HZ_W-1:0]   RST_BIN_HZ        = 6'd15;
  localparam logic [AMP_W-1:0]  RST_TRIGGER_LEVEL = 31'd500;
  localparam logic [FREQ_W-1:0] RST_MIN_FREQ      = 15'd250;
  localparam logic [FREQ_W-1:0] RST_PRIM_LOW      = 15'd5055;
  localparam logic [FREQ_W-1:0] RST_PRIM_HIGH     = 15'd5755;
  localparam logic [FREQ_W-1:0] RST_SEC_LOW       = 15'd4500;
  localparam logic [FREQ_W-1:0] RST_SEC_HIGH      = 15'd7500;
  localparam logic [AMP_W-1:0]  RST_NOISE_LEVEL   = 31'd3500;

  typedef struct packed {
    logic [HZ_W-1:0]   bin_hz;
    logic [AMP_W-1:0]  trigger_level;
    logic [FREQ_W-1:0] min_freq;
    logic [FREQ_W-1:0] prim_low;
    logic [FREQ_W-1:0] prim_high;
    logic [FREQ_W-1:0] sec_low;
    logic [FREQ_W-1:0] sec_high;
    logic [AMP_W-1:0]  noise_level;
  } cfg_t;

endpackage

// File: sv/stpd_fifo.sv
// ---------------------------------------------------------------------------
// stpd_fifo
// Small register queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module stpd_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: sv/stpd_front.sv
// ---------------------------------------------------------------------------
// stpd_front
// Takes bins, tracks the saturated magnitude peak and hands a frame record
// (peak bin, prior peak bin, peak amplitude) to the back end.
// ---------------------------------------------------------------------------
module stpd_front
  import stpd_pkg::*;
#(
  parameter int NUM_BINS = NUM_BINS_DEF,
  parameter int BIN_W    = $clog2(NUM_BINS),
  parameter int REC_W    = 2 * BIN_W + AMP_W
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic signed [BIN_VALUE_W-1:0] in_bin_value,
  output logic                   rec_push,
  input  logic                   rec_full,
  output logic [REC_W-1:0]       rec_data
);

  logic [BIN_W-1:0] bin_count_r, bin_count_nxt;
  logic [AMP_W-1:0] running_max_r, running_max_nxt;
  logic [BIN_W-1:0] peak_bin_r, peak_bin_nxt;
  logic [BIN_W-1:0] prior_peak_bin_r, prior_peak_bin_nxt;
  logic             accept, last_bin;
  logic [BIN_VALUE_W-1:0] neg_val;
  logic [AMP_W-1:0] mag;

  assign in_full  = rec_full;
  assign accept   = in_push && !rec_full;
  assign last_bin = (bin_count_r == BIN_W'(NUM_BINS - 1));

  // magnitude, most negative value saturates
  always_comb begin
    neg_val = '0 - BIN_VALUE_W'(in_bin_value);
    if (in_bin_value[BIN_VALUE_W-1]) begin
      mag = neg_val[BIN_VALUE_W-1] ? '1 : neg_val[AMP_W-1:0];
    end else begin
      mag = in_bin_value[AMP_W-1:0];
    end
  end

  // running peak and frame position
  always_comb begin
    bin_count_nxt      = bin_count_r;
    running_max_nxt    = running_max_r;
    peak_bin_nxt       = peak_bin_r;
    prior_peak_bin_nxt = prior_peak_bin_r;
    if (accept) begin
      bin_count_nxt = last_bin ? '0 : bin_count_r + 1'b1;
      if (bin_count_r == '0) begin
        running_max_nxt    = '0;
        peak_bin_nxt       = '0;
        prior_peak_bin_nxt = '0;
      end else if (mag > running_max_r) begin
        running_max_nxt    = mag;
        prior_peak_bin_nxt = peak_bin_r;
        peak_bin_nxt       = bin_count_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r      <= '0;
      running_max_r    <= '0;
      peak_bin_r       <= '0;
      prior_peak_bin_r <= '0;
    end else begin
      bin_count_r      <= bin_count_nxt;
      running_max_r    <= running_max_nxt;
      peak_bin_r       <= peak_bin_nxt;
      prior_peak_bin_r <= prior_peak_bin_nxt;
    end
  end

  // frame record on the last bin
  assign rec_push = accept && last_bin;
  assign rec_data = {peak_bin_nxt, prior_peak_bin_nxt, running_max_nxt};

endmodule

// File: sv/stpd_back.sv
// ---------------------------------------------------------------------------
// stpd_back
// Gates frequencies, shifts the history stores and decides one frame.
// Each record steps through shift, compare, emit.
// ---------------------------------------------------------------------------
module stpd_back
  import stpd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int BIN_W         = $clog2(NUM_BINS_DEF),
  parameter int REC_W         = 2 * BIN_W + AMP_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             rec_empty,
  output logic             rec_pop,
  input  logic [REC_W-1:0] rec_data,
  output logic             res_push,
  input  logic             res_full,
  output logic             res_detected
);

  localparam int EDGE_N = HISTORY_DEPTH / 4;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_OUT  = 3'b100
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [FREQ_W-1:0] prim_hist_r [HISTORY_DEPTH];
  logic [FREQ_W-1:0] sec_hist_r  [HISTORY_DEPTH];
  logic [AMP_W-1:0]  amp_hist_r  [HISTORY_DEPTH];

  logic [HISTORY_DEPTH-1:0] prim_hit_r, prim_hit_nxt;
  logic [HISTORY_DEPTH-1:0] sec_hit_r, sec_hit_nxt;
  logic [2*EDGE_N-1:0]      amp_ok_r, amp_ok_nxt;

  logic [BIN_W-1:0]  rec_peak, rec_prior;
  logic [AMP_W-1:0]  rec_amp;
  logic [31:0]       prim_prod, sec_prod;
  logic [FREQ_W-1:0] prim_f, sec_f, prim_gated, sec_gated;
  logic              trig_ok;

  assign rec_amp   = rec_data[AMP_W-1:0];
  assign rec_prior = rec_data[AMP_W +: BIN_W];
  assign rec_peak  = rec_data[AMP_W+BIN_W +: BIN_W];

  // frequency = bin * bin_hz, kept to 15 bits, then gated
  always_comb begin
    prim_prod  = 32'(rec_peak) * 32'(cfg.bin_hz);
    sec_prod   = 32'(rec_prior) * 32'(cfg.bin_hz);
    prim_f     = prim_prod[FREQ_W-1:0];
    sec_f      = sec_prod[FREQ_W-1:0];
    trig_ok    = rec_amp > cfg.trigger_level;
    prim_gated = (trig_ok && prim_f > cfg.min_freq) ? prim_f : '0;
    sec_gated  = (trig_ok && sec_f > cfg.min_freq) ? sec_f : '0;
  end

  // control
  assign rec_pop  = (state_r == ST_IDLE) && !rec_empty;
  assign res_push = (state_r == ST_OUT) && !res_full;
  assign res_detected = (|prim_hit_r) && (|sec_hit_r) && (&amp_ok_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!rec_empty) state_nxt = ST_CMP;
      ST_CMP:  state_nxt = ST_OUT;
      ST_OUT:  if (!res_full) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // history stores, entry 0 newest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < HISTORY_DEPTH; j++) begin
        prim_hist_r[j] <= '0;
        sec_hist_r[j]  <= '0;
        amp_hist_r[j]  <= '0;
      end
    end else if (rec_pop) begin
      prim_hist_r[0] <= prim_gated;
      sec_hist_r[0]  <= sec_gated;
      amp_hist_r[0]  <= rec_amp;
      for (int j = 1; j < HISTORY_DEPTH; j++) begin
        prim_hist_r[j] <= prim_hist_r[j-1];
        sec_hist_r[j]  <= sec_hist_r[j-1];
        amp_hist_r[j]  <= amp_hist_r[j-1];
      end
    end
  end

  // per-entry window hits; edge amplitudes all below noise means max below
  always_comb begin
    for (int j = 0; j < HISTORY_DEPTH; j++) begin
      prim_hit_nxt[j] = (prim_hist_r[j] > cfg.prim_low) && (prim_hist_r[j] < cfg.prim_high);
      sec_hit_nxt[j]  = (sec_hist_r[j] > cfg.sec_low) && (sec_hist_r[j] < cfg.sec_high);
    end
    for (int j = 0; j < EDGE_N; j++) begin
      amp_ok_nxt[j]          = amp_hist_r[j] < cfg.noise_level;
      amp_ok_nxt[EDGE_N + j] = amp_hist_r[HISTORY_DEPTH-1-j] < cfg.noise_level;
    end
  end

  always_ff @(posedge clk) begin
    prim_hit_r <= prim_hit_nxt;
    sec_hit_r  <= sec_hit_nxt;
    amp_ok_r   <= amp_ok_nxt;
  end

endmodule

// File: sv/spectral_tone_pair_detector.sv
// ---------------------------------------------------------------------------
// spectral_tone_pair_detector
// Peak tracking over spectrum frames and tone pair decision over history.
// ---------------------------------------------------------------------------
//  channel   ports                                 handshake
//  input     in_push, in_full, in_bin_value        push && !full
//  result    out_pop, out_empty, out_detected      pop && !empty
//  config    cfg_we, cfg_index, cfg_wdata          we, no wait
//
//  One bin per cycle unless in_full; the front peak tracker takes a bin every
//  cycle that the frame queue has room. One result per frame, made by the back
//  end's shift, compare and emit steps; it pops a new record only when idle.
//  Reset is synchronous and clears the history stores at once: no sweep.
//  Input stalls whenever the frame queue is full.
// ---------------------------------------------------------------------------
`include "spectral_tone_pair_detector_macros.svh"

module spectral_tone_pair_detector
  import stpd_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int NUM_BINS      = NUM_BINS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic signed [BIN_VALUE_W-1:0] in_bin_value,
  input  logic                          out_pop,
  output logic                          out_empty,
  output logic                          out_detected,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int BIN_W = $clog2(NUM_BINS);
  localparam int REC_W = 2 * BIN_W + AMP_W;

  cfg_t cfg_r, cfg_nxt;

  logic             mid_push, mid_full, mid_pop, mid_empty;
  logic [REC_W-1:0] mid_wdata, mid_rdata;
  logic             res_push, res_full, res_detected;

  // configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_BIN_HZ:        cfg_nxt.bin_hz        = cfg_wdata[HZ_W-1:0];
        CFG_TRIGGER_LEVEL: cfg_nxt.trigger_level = cfg_wdata[AMP_W-1:0];
        CFG_MIN_FREQ:      cfg_nxt.min_freq      = cfg_wdata[FREQ_W-1:0];
        CFG_PRIM_LOW:      cfg_nxt.prim_low      = cfg_wdata[FREQ_W-1:0];
        CFG_PRIM_HIGH:     cfg_nxt.prim_high     = cfg_wdata[FREQ_W-1:0];
        CFG_SEC_LOW:       cfg_nxt.sec_low       = cfg_wdata[FREQ_W-1:0];
        CFG_SEC_HIGH:      cfg_nxt.sec_high      = cfg_wdata[FREQ_W-1:0];
        CFG_NOISE_LEVEL:   cfg_nxt.noise_level   = cfg_wdata[AMP_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bin_hz        <= RST_BIN_HZ;
      cfg_r.trigger_level <= RST_TRIGGER_LEVEL;
      cfg_r.min_freq      <= RST_MIN_FREQ;
      cfg_r.prim_low      <= RST_PRIM_LOW;
      cfg_r.prim_high     <= RST_PRIM_HIGH;
      cfg_r.sec_low       <= RST_SEC_LOW;
      cfg_r.sec_high      <= RST_SEC_HIGH;
      cfg_r.noise_level   <= RST_NOISE_LEVEL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: peak tracking
  stpd_front #(
    .NUM_BINS (NUM_BINS),
    .BIN_W    (BIN_W),
    .REC_W    (REC_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_bin_value (in_bin_value),
    .rec_push     (mid_push),
    .rec_full     (mid_full),
    .rec_data     (mid_wdata)
  );

  // frame record queue
  stpd_fifo #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .full  (mid_full),
    .wdata (mid_wdata),
    .pop   (mid_pop),
    .empty (mid_empty),
    .rdata (mid_rdata)
  );

  // back: history and decision
  stpd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .BIN_W         (BIN_W),
    .REC_W         (REC_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .rec_empty    (mid_empty),
    .rec_pop      (mid_pop),
    .rec_data     (mid_rdata),
    .res_push     (res_push),
    .res_full     (res_full),
    .res_detected (res_detected)
  );

  // result queue
  stpd_fifo #(
    .WIDTH (1),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .wdata (res_detected),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (out_detected)
  );

  // checks
  `STPD_ASSERT_NOW(a_mid_no_overflow, mid_push, !mid_full, "frame record pushed into full queue")
  `STPD_ASSERT_NEXT(a_mid_holds_rec, mid_push, !mid_empty, "frame record lost after push")
  `STPD_ASSERT_NOW(a_res_no_overflow, res_push, !res_full, "result pushed into full queue")
  `STPD_ASSERT_NOW(a_pop_has_rec, mid_pop, !mid_empty, "back end popped an empty queue")

endmodule
